### rtl/sha256_byte_stream_hasher_core_assert.svh
// assertion macros for the sha-256 byte stream hasher
`ifndef SHA256_BYTE_STREAM_HASHER_CORE_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_CORE_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define SHABSH_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define SHABSH_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/shabsh_pkg.sv
// ----------------------------------------------------------------------------
// shabsh_pkg
// shared types, constants and tables of the sha-256 byte stream hasher
// ----------------------------------------------------------------------------
`default_nettype none

package shabsh_pkg;

   localparam int unsigned WordW       = 32;
   localparam int unsigned ByteW       = 8;
   localparam int unsigned BlockBits   = 512;
   localparam int unsigned Rounds      = 64;
   localparam int unsigned DigestWords = 8;
   localparam int unsigned LenW        = 64;
   localparam int unsigned RoundW      = $clog2(Rounds);
   localparam int unsigned IdxW        = $clog2(DigestWords);
   localparam int unsigned FillW       = 6;

   localparam logic [ByteW-1:0]  PadByte   = 8'h80;
   localparam logic [FillW-1:0]  LenFill   = 6'd56;
   localparam logic [FillW-1:0]  FullFill  = 6'd63;
   localparam logic [RoundW-1:0] LastRound = RoundW'(Rounds - 1);
   localparam logic [IdxW-1:0]   LastWord  = IdxW'(DigestWords - 1);

   typedef logic [WordW-1:0] word_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_ADD,
      ST_PAD_ONE,
      ST_PAD_ZERO,
      ST_PAD_LEN,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      BSEL_MSG,
      BSEL_PAD,
      BSEL_ZERO,
      BSEL_LEN
   } byte_sel_type;

   typedef struct packed {
      logic              load_byte;
      byte_sel_type      byte_sel;
      logic              count_bits;
      logic              load_work;
      logic              do_round;
      logic [RoundW-1:0] round_idx;
      logic              add_hash;
      logic              restart;
      logic [IdxW-1:0]   out_idx;
   } cmd_type;

   typedef struct packed {
      logic fill_full;
      logic fill_len;
   } status_type;

   function automatic word_type k_const(input logic [RoundW-1:0] idx);
      word_type k;
      case (idx)
         6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
         6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
         6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
         6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
         6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
         6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
         6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
         6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
         6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
         6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
         6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
         6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
         6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
         6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
         6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
         6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
         6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
         6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
         6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
         6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
         6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
         6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
         6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
         6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
         6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
         6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
         6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
         6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
         6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
         6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
         6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
         6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
         default: k = '0;
      endcase
      return k;
   endfunction

   function automatic word_type iv_const(input logic [IdxW-1:0] idx);
      word_type h;
      case (idx)
         3'd0: h = 32'h6a09e667;
         3'd1: h = 32'hbb67ae85;
         3'd2: h = 32'h3c6ef372;
         3'd3: h = 32'ha54ff53a;
         3'd4: h = 32'h510e527f;
         3'd5: h = 32'h9b05688c;
         3'd6: h = 32'h1f83d9ab;
         3'd7: h = 32'h5be0cd19;
         default: h = '0;
      endcase
      return h;
   endfunction

endpackage

`default_nettype wire

### rtl/shabsh_if.sv
// ----------------------------------------------------------------------------
// shabsh_if
// valid/ready channels carrying message bytes in and digest words out
// ----------------------------------------------------------------------------
`default_nettype none

interface shabsh_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       has_byte;
   logic       end_of_message;

   modport source (output valid, output data_byte, output has_byte,
                   output end_of_message, input ready);
   modport sink   (input valid, input data_byte, input has_byte,
                   input end_of_message, output ready);
endinterface

interface shabsh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;

   modport source (output valid, output digest_word, output word_index,
                   output last_word, input ready);
   modport sink   (input valid, input digest_word, input word_index,
                   input last_word, output ready);
endinterface

`default_nettype wire

### rtl/shabsh_ctrl.sv
// ----------------------------------------------------------------------------
// shabsh_ctrl
// sequencer: byte loading, padding, round counting and digest readout
// ----------------------------------------------------------------------------
`default_nettype none

module shabsh_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_has_byte,
   input  wire logic                 req_end,
   output logic                      req_ready,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire shabsh_pkg::status_type status,
   output shabsh_pkg::cmd_type       cmd
);
   import shabsh_pkg::*;

   state_type         state_ff, state_in;
   state_type         ret_ff, ret_in;
   logic [RoundW-1:0] round_ff, round_in;
   logic [IdxW-1:0]   out_ff, out_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         round_ff <= '0;
         out_ff   <= '0;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         round_ff <= round_in;
         out_ff   <= out_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      ret_in         = ret_ff;
      round_in       = round_ff;
      out_in         = out_ff;
      req_ready      = 1'b0;
      rsp_valid      = 1'b0;
      cmd            = '0;
      cmd.byte_sel   = BSEL_MSG;
      cmd.round_idx  = round_ff;
      cmd.out_idx    = out_ff;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_has_byte) begin
                  cmd.load_byte  = 1'b1;
                  cmd.count_bits = 1'b1;
                  if (status.fill_full) begin
                     state_in = ST_LOAD;
                     ret_in   = req_end ? ST_PAD_ONE : ST_IDLE;
                  end else if (req_end) begin
                     state_in = ST_PAD_ONE;
                  end
               end else if (req_end) begin
                  state_in = ST_PAD_ONE;
               end
            end
         end
         ST_LOAD: begin
            cmd.load_work = 1'b1;
            round_in      = '0;
            state_in      = ST_ROUND;
         end
         ST_ROUND: begin
            cmd.do_round = 1'b1;
            round_in     = round_ff + 1'b1;
            if (round_ff == LastRound) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            cmd.add_hash = 1'b1;
            state_in     = ret_ff;
         end
         ST_PAD_ONE: begin
            cmd.load_byte = 1'b1;
            cmd.byte_sel  = BSEL_PAD;
            if (status.fill_full) begin
               state_in = ST_LOAD;
               ret_in   = ST_PAD_ZERO;
            end else begin
               state_in = ST_PAD_ZERO;
            end
         end
         ST_PAD_ZERO: begin
            if (status.fill_len) begin
               state_in = ST_PAD_LEN;
            end else begin
               cmd.load_byte = 1'b1;
               cmd.byte_sel  = BSEL_ZERO;
               if (status.fill_full) begin
                  state_in = ST_LOAD;
                  ret_in   = ST_PAD_ZERO;
               end
            end
         end
         ST_PAD_LEN: begin
            cmd.load_byte = 1'b1;
            cmd.byte_sel  = BSEL_LEN;
            if (status.fill_full) begin
               state_in = ST_LOAD;
               ret_in   = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               out_in = out_ff + 1'b1;
               if (out_ff == LastWord) begin
                  cmd.restart = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### rtl/shabsh_datapath.sv
// ----------------------------------------------------------------------------
// shabsh_datapath
// block shift line with rolling schedule, round logic, hash words, bit length
// ----------------------------------------------------------------------------
`default_nettype none

module shabsh_datapath (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [7:0]             data_byte,
   input  wire shabsh_pkg::cmd_type    cmd,
   output shabsh_pkg::status_type      status,
   output shabsh_pkg::word_type        digest_word
);
   import shabsh_pkg::*;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (WordW - n));
   endfunction

   function automatic word_type bsig0(input word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type bsig1(input word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type ssig0(input word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type ssig1(input word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   // block bytes enter at the low end; word 0 sits at the top
   logic [BlockBits-1:0] blk_ff, blk_in;
   logic [FillW-1:0]     fill_ff, fill_in;
   logic [LenW-1:0]      bits_ff, bits_in;
   word_type             hash_ff [DigestWords];
   word_type             hash_in [DigestWords];
   word_type             work_ff [DigestWords];
   word_type             work_in [DigestWords];

   logic [ByteW-1:0] byte_mux;
   word_type         w0, w1, w9, w14, w_new;
   word_type         t1, t2, ch, maj;

   assign w0  = blk_ff[BlockBits-1 -: WordW];
   assign w1  = blk_ff[BlockBits-1-WordW -: WordW];
   assign w9  = blk_ff[BlockBits-1-9*WordW -: WordW];
   assign w14 = blk_ff[BlockBits-1-14*WordW -: WordW];

   always_comb begin
      case (cmd.byte_sel)
         BSEL_MSG:  byte_mux = data_byte;
         BSEL_PAD:  byte_mux = PadByte;
         BSEL_ZERO: byte_mux = '0;
         BSEL_LEN:  byte_mux = bits_ff[LenW-1 -: ByteW];
         default:   byte_mux = '0;
      endcase
   end

   always_comb begin
      w_new = ssig1(w14) + w9 + ssig0(w1) + w0;
      ch    = (work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]);
      maj   = (work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2]) ^
              (work_ff[1] & work_ff[2]);
      t1    = work_ff[7] + bsig1(work_ff[4]) + ch + k_const(cmd.round_idx) + w0;
      t2    = bsig0(work_ff[0]) + maj;
   end

   always_comb begin
      blk_in  = blk_ff;
      fill_in = fill_ff;
      bits_in = bits_ff;
      hash_in = hash_ff;
      work_in = work_ff;
      if (cmd.load_byte) begin
         blk_in  = {blk_ff[BlockBits-ByteW-1:0], byte_mux};
         fill_in = fill_ff + 1'b1;
      end
      if (cmd.do_round) begin
         blk_in = {blk_ff[BlockBits-WordW-1:0], w_new};
         for (int i = 1; i < DigestWords; i++) begin
            work_in[i] = work_ff[i-1];
         end
         work_in[4] = work_ff[3] + t1;
         work_in[0] = t1 + t2;
      end
      if (cmd.count_bits) begin
         bits_in = bits_ff + LenW'(ByteW);
      end
      // length bytes go out msb first, leaving the counter clear
      if (cmd.load_byte && (cmd.byte_sel == BSEL_LEN)) begin
         bits_in = bits_ff << ByteW;
      end
      if (cmd.load_work) begin
         work_in = hash_ff;
      end
      if (cmd.add_hash) begin
         for (int i = 0; i < DigestWords; i++) begin
            hash_in[i] = hash_ff[i] + work_ff[i];
         end
      end
      if (cmd.restart) begin
         for (int i = 0; i < DigestWords; i++) begin
            hash_in[i] = iv_const(IdxW'(i));
         end
         bits_in = '0;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         bits_ff <= '0;
         for (int i = 0; i < DigestWords; i++) begin
            hash_ff[i] <= iv_const(IdxW'(i));
         end
      end else begin
         fill_ff <= fill_in;
         bits_ff <= bits_in;
         hash_ff <= hash_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff  <= blk_in;
      work_ff <= work_in;
   end

   assign status.fill_full = (fill_ff == FullFill);
   assign status.fill_len  = (fill_ff == LenFill);
   assign digest_word      = hash_ff[cmd.out_idx];

endmodule

`default_nettype wire

### rtl/sha256_byte_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core
// sha-256 over a byte stream, digest returned as eight 32-bit words
// ----------------------------------------------------------------------------
// usage:
//   req_port carries one word per handshake: data_byte qualified by has_byte,
//   and end_of_message closing the message after that word's byte. a word
//   with neither flag is taken and dropped.
//   rsp_port returns eight digest words, word_index 0 (most significant)
//   through 7, last_word marking the eighth.
// timing:
//   bytes are taken one per cycle; the 64th byte of a block starts the
//   working-variable load, 64 rounds on the single round unit and the
//   hash add, and input is held off until they finish. after end_of_message,
//   padding shifts one byte per cycle outside compressions: pad byte, zeros
//   and length if the length fits, else pad and zeros to the block end, a
//   compression, zeros and length; then the final compression, then the
//   digest words, one per cycle while rsp_port.ready is high.
//   req_port.ready is high only while the block waits for input.
// reset:
//   synchronous; hash words return to the initial values, length and fill
//   clear. a stalled receiver simply holds the current digest word.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sha256_byte_stream_hasher_core_assert.svh"

module sha256_byte_stream_hasher_core (
   input  wire logic      clock,
   input  wire logic      reset,
   shabsh_req_if.sink     req_port,
   shabsh_rsp_if.source   rsp_port
);
   import shabsh_pkg::*;

   cmd_type    ctrl_cmd;
   status_type dp_status;
   word_type   dp_digest;

   shabsh_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_port.valid),
      .req_has_byte (req_port.has_byte),
      .req_end      (req_port.end_of_message),
      .req_ready    (req_port.ready),
      .rsp_valid    (rsp_port.valid),
      .rsp_ready    (rsp_port.ready),
      .status       (dp_status),
      .cmd          (ctrl_cmd)
   );

   shabsh_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .data_byte   (req_port.data_byte),
      .cmd         (ctrl_cmd),
      .status      (dp_status),
      .digest_word (dp_digest)
   );

   assign rsp_port.digest_word = dp_digest;
   assign rsp_port.word_index  = ctrl_cmd.out_idx;
   assign rsp_port.last_word   = (ctrl_cmd.out_idx == LastWord);

   `SHABSH_ASSERT_NOW(a_out_blocks_in, clock, reset, rsp_port.valid, !req_port.ready, "input open during readout")
   `SHABSH_ASSERT_NEXT(a_ready_after_last, clock, reset, rsp_port.valid && rsp_port.ready && rsp_port.last_word, req_port.ready, "not idle after last digest word")
   `SHABSH_ASSERT_NOW(a_round_no_load, clock, reset, ctrl_cmd.do_round, !ctrl_cmd.load_byte && !ctrl_cmd.add_hash, "round overlaps byte load or hash add")
   `SHABSH_ASSERT_NEXT(a_restart_clears, clock, reset, ctrl_cmd.restart, !dp_status.fill_full && !dp_status.fill_len, "fill not cleared after digest")

endmodule

`default_nettype wire

### tb/sha256_digest_checker.sv
// ----------------------------------------------------------------------------
// sha256_digest_checker
// watches both channels of the byte stream hasher, hashes every accepted
// word in its own sha-256 model and compares each digest word it returns
// ----------------------------------------------------------------------------
`default_nettype none

module sha256_digest_checker (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_ready,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_has_byte,
   input  wire logic                 req_end_of_message,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_ready,
   input  wire shabsh_pkg::word_type rsp_digest_word,
   input  wire logic [2:0]           rsp_word_index,
   input  wire logic                 rsp_last_word,
   output int                        fail_count,
   output int                        words_pending
);
   import shabsh_pkg::*;

   localparam logic [0:63][31:0] RoundK = {
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [0:7][31:0] StartHash = {
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   typedef struct packed {
      word_type        word;
      logic [IdxW-1:0] index;
      logic            last;
   } digest_entry_type;

   word_type         chain_hash [8];
   logic [7:0]       block_bytes [64];
   int unsigned      block_fill;
   logic [63:0]      msg_bit_len;
   digest_entry_type digest_queue [$];
   int               mismatch_total;

   function automatic word_type rotr(input word_type x, input int unsigned n);
      return (x >> n) | (x << (32 - n));
   endfunction

   task automatic restart_message();
      int k;
      for (k = 0; k < 8; k++) chain_hash[k] = StartHash[k];
      block_fill  = 0;
      msg_bit_len = '0;
   endtask

   task automatic compress_block();
      word_type sched [64];
      word_type a, b, c, d, e, f, g, h;
      word_type s0, s1, chs, maj, t1, t2;
      int k;
      for (k = 0; k < 16; k++) begin
         sched[k] = {block_bytes[4*k], block_bytes[4*k+1], block_bytes[4*k+2],
                     block_bytes[4*k+3]};
      end
      for (k = 16; k < 64; k++) begin
         s0 = rotr(sched[k-15], 7) ^ rotr(sched[k-15], 18) ^ (sched[k-15] >> 3);
         s1 = rotr(sched[k-2], 17) ^ rotr(sched[k-2], 19) ^ (sched[k-2] >> 10);
         sched[k] = sched[k-16] + s0 + sched[k-7] + s1;
      end
      a = chain_hash[0]; b = chain_hash[1]; c = chain_hash[2]; d = chain_hash[3];
      e = chain_hash[4]; f = chain_hash[5]; g = chain_hash[6]; h = chain_hash[7];
      for (k = 0; k < 64; k++) begin
         s1  = rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25);
         chs = (e & f) ^ (~e & g);
         t1  = h + s1 + chs + RoundK[k] + sched[k];
         s0  = rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22);
         maj = (a & b) ^ (a & c) ^ (b & c);
         t2  = s0 + maj;
         h = g; g = f; f = e; e = d + t1;
         d = c; c = b; b = a; a = t1 + t2;
      end
      chain_hash[0] += a; chain_hash[1] += b; chain_hash[2] += c; chain_hash[3] += d;
      chain_hash[4] += e; chain_hash[5] += f; chain_hash[6] += g; chain_hash[7] += h;
   endtask

   task automatic hash_word(input logic [7:0] data, input logic has_byte, input logic eom);
      digest_entry_type ent;
      int k;
      if (has_byte) begin
         block_bytes[block_fill] = data;
         block_fill++;
         msg_bit_len += 64'd8;
         if (block_fill == 64) begin
            compress_block();
            block_fill = 0;
         end
      end
      if (eom) begin
         block_bytes[block_fill] = PadByte;
         block_fill++;
         // no room left for the length: close this block and pad a second one
         if (block_fill > 56) begin
            while (block_fill < 64) begin
               block_bytes[block_fill] = 8'h00;
               block_fill++;
            end
            compress_block();
            block_fill = 0;
         end
         while (block_fill < 56) begin
            block_bytes[block_fill] = 8'h00;
            block_fill++;
         end
         for (k = 0; k < 8; k++) block_bytes[56+k] = msg_bit_len[63-8*k -: 8];
         compress_block();
         for (k = 0; k < 8; k++) begin
            ent.word  = chain_hash[k];
            ent.index = k[IdxW-1:0];
            ent.last  = (k == 7);
            digest_queue.push_back(ent);
         end
         restart_message();
      end
   endtask

   always @(posedge clock) begin : watch
      digest_entry_type want;
      if (reset) begin
         restart_message();
         digest_queue.delete();
         mismatch_total = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (digest_queue.size() == 0) begin
               mismatch_total++;
               if (mismatch_total <= 10)
                  $display("unexpected digest word %h index %0d last %b",
                           rsp_digest_word, rsp_word_index, rsp_last_word);
            end else begin
               want = digest_queue.pop_front();
               if (rsp_digest_word !== want.word || rsp_word_index !== want.index ||
                   rsp_last_word !== want.last) begin
                  mismatch_total++;
                  if (mismatch_total <= 10)
                     $display("digest mismatch: expected %h index %0d last %b, got %h index %0d last %b",
                              want.word, want.index, want.last,
                              rsp_digest_word, rsp_word_index, rsp_last_word);
               end
            end
         end
         if (req_valid && req_ready) hash_word(req_data_byte, req_has_byte, req_end_of_message);
      end
      fail_count    <= mismatch_total;
      words_pending <= digest_queue.size();
   end

endmodule

`default_nettype wire

### tb/tb_sha256_byte_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// tb_sha256_byte_stream_hasher_core
// drives messages of random bytes into the hasher in bursts, with empty,
// one-byte and block-boundary messages, idle words and a long receiver
// stall; the digest checker beside the block predicts and compares
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sha256_byte_stream_hasher_core;

   localparam int RandomItems   = 130;
   localparam int HoldOffCycles = 800;
   localparam int DrainCycles   = 300;
   localparam int CycleLimit    = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   cycle_count = 0;
   int   fail_count;
   int   words_pending;
   int   burst_left;
   int   random_items;
   int   random_msgs;
   bit   offering = 1'b0;
   bit   hold_off_request = 1'b0;
   int unsigned boundary_len [6] = '{55, 56, 57, 63, 64, 65};

   shabsh_req_if req_bus ();
   shabsh_rsp_if rsp_bus ();

   sha256_byte_stream_hasher_core dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   sha256_digest_checker digest_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_bus.valid),
      .req_ready          (req_bus.ready),
      .req_data_byte      (req_bus.data_byte),
      .req_has_byte       (req_bus.has_byte),
      .req_end_of_message (req_bus.end_of_message),
      .rsp_valid          (rsp_bus.valid),
      .rsp_ready          (rsp_bus.ready),
      .rsp_digest_word    (rsp_bus.digest_word),
      .rsp_word_index     (rsp_bus.word_index),
      .rsp_last_word      (rsp_bus.last_word),
      .fail_count         (fail_count),
      .words_pending      (words_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // offer one word and hold it until taken; bursts end in a random gap
   task automatic send_word(input logic [7:0] data, input logic has_byte, input logic eom);
      req_bus.valid          <= 1'b1;
      req_bus.data_byte      <= data;
      req_bus.has_byte       <= has_byte;
      req_bus.end_of_message <= eom;
      offering = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      burst_left--;
      if (burst_left <= 0) begin
         req_bus.valid <= 1'b0;
         offering = 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                  : $urandom_range(1, 8);
      end
   endtask

   task automatic send_message(input int unsigned len, input bit noisy);
      int unsigned k;
      bit close_on_byte;
      close_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
      for (k = 0; k < len; k++) begin
         // idle words carry random data that must be dropped
         if (noisy && $urandom_range(0, 11) == 0)
            send_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
         send_word(8'($urandom_range(0, 255)), 1'b1, close_on_byte && (k == len - 1));
         random_items++;
      end
      if (!close_on_byte) begin
         send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1);
         random_items++;
      end
   endtask

   task automatic drain_results();
      if (offering) begin
         req_bus.valid <= 1'b0;
         offering = 1'b0;
      end
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
   endtask

   // receiver: segments of steady, random and sparse ready, plus one long stall
   initial begin : rsp_pacer
      int seg_len;
      int mode;
      int k;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_bus.ready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
         end else begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(4, 60);
            for (k = 0; k < seg_len; k++) begin
               case (mode)
                  0:       rsp_bus.ready <= 1'b1;
                  1:       rsp_bus.ready <= 1'($urandom_range(0, 1));
                  2:       rsp_bus.ready <= ($urandom_range(0, 7) != 0);
                  default: rsp_bus.ready <= ($urandom_range(0, 4) == 0);
               endcase
               @(posedge clock);
            end
         end
      end
   end

   initial begin : stimulus
      int k;
      int unsigned len;
      req_bus.valid          <= 1'b0;
      req_bus.data_byte      <= 8'h00;
      req_bus.has_byte       <= 1'b0;
      req_bus.end_of_message <= 1'b0;
      burst_left   = $urandom_range(1, 8);
      random_items = 0;
      random_msgs  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // empty message, then an idle word with all data bits set
      send_word(8'h00, 1'b0, 1'b1);
      send_word(8'hff, 1'b0, 1'b0);
      // "abc", closed on the last byte
      send_word(8'h61, 1'b1, 1'b0);
      send_word(8'h62, 1'b1, 1'b0);
      send_word(8'h63, 1'b1, 1'b1);
      // extreme bytes, closed by a word with no byte
      send_word(8'h00, 1'b1, 1'b0);
      send_word(8'hff, 1'b1, 1'b0);
      send_word(8'h80, 1'b1, 1'b0);
      send_word(8'hff, 1'b0, 1'b1);
      // single byte carrying the end mark
      send_word(8'hff, 1'b1, 1'b1);
      // idle word between bytes of one message
      send_word(8'h5a, 1'b1, 1'b0);
      send_word(8'h00, 1'b0, 1'b0);
      send_word(8'ha5, 1'b1, 1'b0);
      send_word(8'h00, 1'b0, 1'b1);
      // empty message right after another message
      send_word(8'h01, 1'b0, 1'b1);

      drain_results();

      // long receiver stall while short messages keep coming
      hold_off_request = 1'b1;
      for (k = 0; k < 5; k++) send_message($urandom_range(1, 6), 1'b0);

      random_items = 0;
      while (random_items < RandomItems) begin
         if (random_msgs == 0)
            len = 56;
         else if ($urandom_range(0, 9) == 0)
            len = boundary_len[$urandom_range(0, 5)];
         else
            len = $urandom_range(0, 12);
         send_message(len, 1'b1);
         random_msgs++;
      end

      drain_results();
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0 && words_pending == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule

`default_nettype wire

### filelist.f
+incdir+rtl
rtl/shabsh_pkg.sv
rtl/shabsh_if.sv
rtl/shabsh_ctrl.sv
rtl/shabsh_datapath.sv
rtl/sha256_byte_stream_hasher_core.sv
tb/sha256_digest_checker.sv
tb/tb_sha256_byte_stream_hasher_core.sv
